// ===== src/vuart_pkg.sv =====
// Package for the virtual 16550 register unit: ring sizes, register codes,
// interrupt reason encoding and the priority function. No dependencies.
package vuart_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_RECV  = 2'd2;
	localparam logic [1:0] FUNC_DRAIN = 2'd3;

	localparam logic [2:0] OFS_DATA = 3'd0;
	localparam logic [2:0] OFS_IER  = 3'd1;
	localparam logic [2:0] OFS_IIR  = 3'd2;
	localparam logic [2:0] OFS_LCR  = 3'd3;
	localparam logic [2:0] OFS_LSR  = 3'd5;
	localparam logic [2:0] OFS_SCR  = 3'd7;

	localparam logic [7:0] WHY_NONE    = 8'h01;
	localparam logic [7:0] WHY_LINE    = 8'h06;
	localparam logic [7:0] WHY_RXDATA  = 8'h0C;
	localparam logic [7:0] WHY_TXEMPTY = 8'h02;
	localparam logic [7:0] IIR_FIFOS_ON = 8'hC0;
	localparam logic [7:0] FCR_KEEP     = 8'hC9;
	localparam logic [7:0] LSR_THRE_TEMT = 8'h60;
	localparam logic [7:0] EMPTY_READ    = 8'hFF;
	localparam logic [7:0] DLL_RESET     = 8'(1843200 / 9600 / 16);

	// Highest-priority pending reason, ranked line status, rx data, tx empty.
	function automatic logic [7:0] int_reason(input logic [7:0] lsr,
		input logic [3:0] ier, input logic rx_nonempty, input logic tx_pend);
		logic [7:0] why;
		if (lsr[1] && ier[2]) begin
			why = WHY_LINE;
		end else if (rx_nonempty && ier[0]) begin
			why = WHY_RXDATA;
		end else if (tx_pend && ier[1]) begin
			why = WHY_TXEMPTY;
		end else begin
			why = WHY_NONE;
		end
		return why;
	endfunction

endpackage

// ===== src/vuart_if.sv =====
// Valid/ready channels for the virtual 16550 register unit: access items in,
// result items out. No dependencies.
interface vuart_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [2:0] offset;
	logic [7:0] wdata;

	modport source (output valid, func, offset, wdata, input ready);
	modport sink (input valid, func, offset, wdata, output ready);
endinterface

interface vuart_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rdata;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       irq_pulse;

	modport source (output valid, rdata, tx_byte, tx_valid, irq_pulse, input ready);
	modport sink (input valid, rdata, tx_byte, tx_valid, irq_pulse, output ready);
endinterface

// ===== src/vuart_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read data.
// Stand-alone; used for the receive and transmit rings.
module vuart_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/virtual_uart_16550_registers_unit.sv =====
// Top level of the virtual 16550 register unit. Depends on vuart_pkg,
// vuart_if and vuart_ram.
//
// One item enters per clock unless the output stage stalls. An accepted
// beat sits in the input stage, where the register file and both rings
// update and the ring RAM reads are issued; its result then moves to the
// output stage. The ring RAMs (RX_DEPTH and TX_DEPTH bytes) carry no reset;
// their pointers and counts do. A stalled output stage holds the input stage,
// which holds the request channel. The user is to assert cfg_we, which writes
// console_q (console active) only while the unit is idle; nothing enforces it.
module virtual_uart_16550_registers_unit (
	input  logic clk,
	input  logic arst_n,
	vuart_req_if.sink   req,
	vuart_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic cfg_wdata
);
	import vuart_pkg::*;

	logic             console_q;
	logic [RX_AW-1:0] rx_rd_q, rx_wr_q;
	logic [RX_CW-1:0] rx_cnt_q;
	logic [TX_AW-1:0] tx_rd_q, tx_wr_q;
	logic [TX_CW-1:0] tx_cnt_q;
	logic [3:0]       ier_q;
	logic [7:0]       lcr_q, fcr_q, scr_q, dll_q, dlh_q, lsr_q;
	logic             pend_q;

	logic       v_s1;
	logic [1:0] func_s1;
	logic [2:0] offset_s1;
	logic [7:0] wdata_s1;

	logic       v_s2;
	logic [7:0] rdata_s2;
	logic       rx_mem_s2;
	logic       tx_valid_s2;
	logic       irq_s2;

	logic adv_s1, load_s2;
	assign load_s2 = !v_s2 || rsp.ready;
	assign adv_s1  = v_s1 && load_s2;
	assign req.ready = !v_s1 || load_s2;

	// next-state logic for the item in the input stage
	logic             rx_push, rx_pop, rx_clr, tx_push, tx_pop;
	logic [RX_AW-1:0] rx_rd_n, rx_wr_n;
	logic [RX_CW-1:0] rx_cnt_n;
	logic [TX_AW-1:0] tx_rd_n, tx_wr_n;
	logic [TX_CW-1:0] tx_cnt_n;
	logic [3:0]       ier_n;
	logic [7:0]       lcr_n, fcr_n, scr_n, dll_n, dlh_n, lsr_n;
	logic             pend_n;
	logic [7:0]       rdata_n, why;
	logic             rx_mem_n, irq_n, dlab;

	always_comb begin
		ier_n = ier_q; lcr_n = lcr_q; fcr_n = fcr_q; scr_n = scr_q;
		dll_n = dll_q; dlh_n = dlh_q; lsr_n = lsr_q; pend_n = pend_q;
		rx_push = 1'b0; rx_pop = 1'b0; rx_clr = 1'b0;
		tx_push = 1'b0; tx_pop = 1'b0;
		rdata_n = 8'h00; rx_mem_n = 1'b0; irq_n = 1'b0;
		dlab = lcr_q[7];
		why = int_reason(lsr_q, ier_q, rx_cnt_q != '0, pend_q);
		case (func_s1)
			FUNC_READ: begin
				if (dlab && offset_s1 == OFS_DATA) begin
					rdata_n = dll_q;
				end else if (dlab && offset_s1 == OFS_IER) begin
					rdata_n = dlh_q;
				end else begin
					unique case (offset_s1)
						OFS_DATA: begin
							lsr_n[1] = 1'b0;
							if (rx_cnt_q != '0) begin
								rx_pop = 1'b1;
								rx_mem_n = 1'b1;
							end else begin
								rdata_n = EMPTY_READ;
							end
						end
						OFS_IER: rdata_n = {4'h0, ier_q};
						OFS_IIR: begin
							if (why == WHY_TXEMPTY) begin
								pend_n = 1'b0;
							end
							rdata_n = (fcr_q[0] ? IIR_FIFOS_ON : 8'h00) | why;
						end
						OFS_LCR: rdata_n = lcr_q;
						OFS_LSR: begin
							rdata_n = lsr_q | LSR_THRE_TEMT;
							rdata_n[0] = rx_cnt_q != '0;
							lsr_n = rdata_n;
							lsr_n[1] = 1'b0;
						end
						OFS_SCR: rdata_n = scr_q;
						default: rdata_n = 8'h00;
					endcase
				end
			end
			FUNC_WRITE: begin
				if (dlab && offset_s1 == OFS_DATA) begin
					dll_n = wdata_s1;
				end else if (dlab && offset_s1 == OFS_IER) begin
					dlh_n = wdata_s1;
				end else begin
					unique case (offset_s1)
						OFS_DATA: begin
							tx_push = 1'b1;
							pend_n = 1'b1;
						end
						OFS_IER: ier_n = wdata_s1[3:0];
						OFS_IIR: begin
							if (!wdata_s1[0]) begin
								fcr_n = 8'h00;
							end else begin
								rx_clr = wdata_s1[1];
								fcr_n = wdata_s1 & FCR_KEEP;
							end
						end
						OFS_LCR: lcr_n = wdata_s1;
						OFS_SCR: scr_n = wdata_s1;
						default: ;
					endcase
				end
			end
			FUNC_RECV: rx_push = console_q;
			default: tx_pop = console_q && (tx_cnt_q != '0);
		endcase

		// receive ring pointers: overwrite the oldest entry when full
		rx_rd_n = rx_rd_q; rx_wr_n = rx_wr_q; rx_cnt_n = rx_cnt_q;
		if (rx_clr) begin
			rx_rd_n = '0; rx_wr_n = '0; rx_cnt_n = '0;
		end else if (rx_push) begin
			if (rx_cnt_q < RX_CW'(RX_DEPTH)) begin
				rx_cnt_n = rx_cnt_q + 1'b1;
			end else begin
				rx_rd_n = (rx_rd_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
			end
			rx_wr_n = (rx_wr_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_q + 1'b1;
		end else if (rx_pop) begin
			rx_rd_n = (rx_rd_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
			rx_cnt_n = rx_cnt_q - 1'b1;
		end

		tx_rd_n = tx_rd_q; tx_wr_n = tx_wr_q; tx_cnt_n = tx_cnt_q;
		if (tx_push) begin
			if (tx_cnt_q < TX_CW'(TX_DEPTH)) begin
				tx_cnt_n = tx_cnt_q + 1'b1;
			end else begin
				tx_rd_n = (tx_rd_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;
			end
			tx_wr_n = (tx_wr_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_q + 1'b1;
		end else if (tx_pop) begin
			tx_rd_n = (tx_rd_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;
			tx_cnt_n = tx_cnt_q - 1'b1;
		end

		if (func_s1 == FUNC_READ || func_s1 == FUNC_WRITE || rx_push) begin
			irq_n = int_reason(lsr_n, ier_n, rx_cnt_n != '0, pend_n) != WHY_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1   <= req.func;
			offset_s1 <= req.offset;
			wdata_s1  <= req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_q <= 1'b0;
			rx_rd_q <= '0; rx_wr_q <= '0; rx_cnt_q <= '0;
			tx_rd_q <= '0; tx_wr_q <= '0; tx_cnt_q <= '0;
			ier_q <= '0; lcr_q <= '0; fcr_q <= '0; scr_q <= '0;
			dll_q <= DLL_RESET; dlh_q <= '0; lsr_q <= '0; pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				console_q <= cfg_wdata;
			end
			if (adv_s1) begin
				rx_rd_q <= rx_rd_n; rx_wr_q <= rx_wr_n; rx_cnt_q <= rx_cnt_n;
				tx_rd_q <= tx_rd_n; tx_wr_q <= tx_wr_n; tx_cnt_q <= tx_cnt_n;
				ier_q <= ier_n; lcr_q <= lcr_n; fcr_q <= fcr_n; scr_q <= scr_n;
				dll_q <= dll_n; dlh_q <= dlh_n; lsr_q <= lsr_n; pend_q <= pend_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rdata_s2    <= rdata_n;
			rx_mem_s2   <= rx_mem_n;
			tx_valid_s2 <= tx_pop;
			irq_s2      <= irq_n;
		end
	end

	logic [7:0] rx_rd_data, tx_rd_data;

	vuart_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (adv_s1 && rx_push),
		.waddr (rx_wr_q),
		.wdata (wdata_s1),
		.re    (adv_s1 && rx_pop),
		.raddr (rx_rd_q),
		.rdata (rx_rd_data)
	);

	vuart_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk   (clk),
		.we    (adv_s1 && tx_push),
		.waddr (tx_wr_q),
		.wdata (wdata_s1),
		.re    (adv_s1 && tx_pop),
		.raddr (tx_rd_q),
		.rdata (tx_rd_data)
	);

	assign rsp.valid     = v_s2;
	assign rsp.rdata     = rx_mem_s2 ? rx_rd_data : rdata_s2;
	assign rsp.tx_byte   = tx_valid_s2 ? tx_rd_data : 8'h00;
	assign rsp.tx_valid  = tx_valid_s2;
	assign rsp.irq_pulse = irq_s2;

	a_rx_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_cnt_q <= RX_CW'(RX_DEPTH))
		else $error("receive count beyond ring depth");

	a_rx_ptr_span: assert property (@(posedge clk) disable iff (!arst_n)
		RX_AW'(rx_wr_q - rx_rd_q) == rx_cnt_q[RX_AW-1:0])
		else $error("receive pointers disagree with count");

	a_tx_ptr_span: assert property (@(posedge clk) disable iff (!arst_n)
		TX_AW'(tx_wr_q - tx_rd_q) == tx_cnt_q[TX_AW-1:0])
		else $error("transmit pointers disagree with count");

	a_drain_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && func_s1 == FUNC_DRAIN |=> !irq_s2 && rdata_s2 == 8'h00)
		else $error("drain result carries read data or interrupt");
endmodule

// ===== tb/sv/vuart_tb_pkg.sv =====
// Beat types, 16550 bit positions and the tracking scoreboard for the virtual
// 16550 register unit testbench. Depends on vuart_pkg.
`timescale 1ns / 100ps
package vuart_tb_pkg;
	import vuart_pkg::*;

	localparam logic [2:0] OFS_FCR = OFS_IIR;
	localparam logic [2:0] OFS_MCR = 3'd4;
	localparam logic [2:0] OFS_MSR = 3'd6;

	localparam int DIV_ACCESS_POS = 7;
	localparam int IER_RX    = 0;
	localparam int IER_TX    = 1;
	localparam int IER_LS    = 2;
	localparam int FCR_EN    = 0;
	localparam int FCR_RXRST = 1;
	localparam int LSR_DR    = 0;
	localparam int LSR_OE    = 1;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] offset;
		logic [7:0] wdata;
	} access_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       irq_pulse;
	} result_t;

	// Tracks the register file and both rings in access order and checks
	// each result beat against the oldest predicted one.
	class vuart_tracker;
		bit [7:0]       rx_mem [RX_DEPTH];
		bit [RX_AW-1:0] rx_rd;
		bit [RX_AW-1:0] rx_wr;
		bit [RX_CW-1:0] rx_count;
		bit [7:0]       tx_mem [TX_DEPTH];
		bit [TX_AW-1:0] tx_rd;
		bit [TX_AW-1:0] tx_wr;
		bit [TX_CW-1:0] tx_count;
		bit [3:0]       int_en;
		bit [7:0]       line_ctl;
		bit [7:0]       fifo_ctl;
		bit [7:0]       scratch;
		bit [7:0]       div_lo = DLL_RESET;
		bit [7:0]       div_hi;
		bit [7:0]       line_stat;
		bit             thre_pend;
		bit             console_on;

		result_t pending_results[$];

		int unsigned errors;
		int unsigned noted;
		int unsigned checked;
		int unsigned rx_overwrites;
		int unsigned tx_overwrites;
		int unsigned empty_reads;
		int unsigned thre_clears;
		int unsigned tx_pops;
		int unsigned irq_pulses;

		function void set_console(input bit on);
			console_on = on;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function logic [7:0] irq_reason();
			if (line_stat[LSR_OE] && int_en[IER_LS]) begin
				return WHY_LINE;
			end
			if (rx_count != 0 && int_en[IER_RX]) begin
				return WHY_RXDATA;
			end
			if (thre_pend && int_en[IER_TX]) begin
				return WHY_TXEMPTY;
			end
			return WHY_NONE;
		endfunction

		function void note_access(input access_t a);
			result_t exp;
			logic [7:0] why;
			logic dlab;
			exp = '0;
			dlab = line_ctl[DIV_ACCESS_POS];
			noted++;
			case (a.func)
			FUNC_READ: begin
				if (dlab && a.offset == OFS_DATA) begin
					exp.rdata = div_lo;
				end else if (dlab && a.offset == OFS_IER) begin
					exp.rdata = div_hi;
				end else begin
					case (a.offset)
					OFS_DATA: begin
						line_stat[LSR_OE] = 1'b0;
						if (rx_count == 0) begin
							exp.rdata = EMPTY_READ;
							empty_reads++;
						end else begin
							exp.rdata = rx_mem[rx_rd];
							rx_rd = (rx_rd == RX_DEPTH - 1) ? '0 : rx_rd + 1'b1;
							rx_count--;
						end
					end
					OFS_IER: exp.rdata = {4'h0, int_en};
					OFS_IIR: begin
						why = irq_reason();
						if (why == WHY_TXEMPTY) begin
							thre_pend = 1'b0;
							thre_clears++;
						end
						exp.rdata = (fifo_ctl[FCR_EN] ? IIR_FIFOS_ON : 8'h00) | why;
					end
					OFS_LCR: exp.rdata = line_ctl;
					OFS_LSR: begin
						line_stat = line_stat | LSR_THRE_TEMT;
						line_stat[LSR_DR] = (rx_count != 0);
						exp.rdata = line_stat;
						line_stat[LSR_OE] = 1'b0;
					end
					OFS_SCR: exp.rdata = scratch;
					default: exp.rdata = 8'h00;
					endcase
				end
				exp.irq_pulse = (irq_reason() != WHY_NONE);
			end
			FUNC_WRITE: begin
				if (dlab && a.offset == OFS_DATA) begin
					div_lo = a.wdata;
				end else if (dlab && a.offset == OFS_IER) begin
					div_hi = a.wdata;
				end else begin
					case (a.offset)
					OFS_DATA: begin
						tx_mem[tx_wr] = a.wdata;
						if (tx_count < TX_DEPTH) begin
							tx_count++;
						end else begin
							// full: drop the oldest byte
							tx_rd = (tx_rd == TX_DEPTH - 1) ? '0 : tx_rd + 1'b1;
							tx_overwrites++;
						end
						tx_wr = (tx_wr == TX_DEPTH - 1) ? '0 : tx_wr + 1'b1;
						thre_pend = 1'b1;
					end
					OFS_IER: int_en = a.wdata[3:0];
					OFS_FCR: begin
						if (!a.wdata[FCR_EN]) begin
							fifo_ctl = 8'h00;
						end else begin
							if (a.wdata[FCR_RXRST]) begin
								rx_rd = '0;
								rx_wr = '0;
								rx_count = '0;
							end
							fifo_ctl = a.wdata & FCR_KEEP;
						end
					end
					OFS_LCR: line_ctl = a.wdata;
					OFS_SCR: scratch = a.wdata;
					default: ;
					endcase
				end
				exp.irq_pulse = (irq_reason() != WHY_NONE);
			end
			FUNC_RECV: begin
				if (console_on) begin
					rx_mem[rx_wr] = a.wdata;
					if (rx_count < RX_DEPTH) begin
						rx_count++;
					end else begin
						rx_rd = (rx_rd == RX_DEPTH - 1) ? '0 : rx_rd + 1'b1;
						rx_overwrites++;
					end
					rx_wr = (rx_wr == RX_DEPTH - 1) ? '0 : rx_wr + 1'b1;
					exp.irq_pulse = (irq_reason() != WHY_NONE);
				end
			end
			default: begin
				if (console_on && tx_count != 0) begin
					exp.tx_byte = tx_mem[tx_rd];
					exp.tx_valid = 1'b1;
					tx_rd = (tx_rd == TX_DEPTH - 1) ? '0 : tx_rd + 1'b1;
					tx_count--;
					tx_pops++;
				end
			end
			endcase
			if (exp.irq_pulse) begin
				irq_pulses++;
			end
			pending_results.push_back(exp);
		endfunction

		function void check_result(input result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("extra result: rdata=%02h tx_byte=%02h tx_valid=%0b irq=%0b",
						got.rdata, got.tx_byte, got.tx_valid, got.irq_pulse);
				end
				return;
			end
			exp = pending_results.pop_front();
			checked++;
			if (got.rdata !== exp.rdata || got.tx_byte !== exp.tx_byte ||
				got.tx_valid !== exp.tx_valid || got.irq_pulse !== exp.irq_pulse) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("res %0d exp/got rdata %02h/%02h txb %02h/%02h txv %0b/%0b irq %0b/%0b",
						checked, exp.rdata, got.rdata, exp.tx_byte, got.tx_byte,
						exp.tx_valid, got.tx_valid, exp.irq_pulse, got.irq_pulse);
				end
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top of the virtual 16550 register unit testbench: clock, reset, request
// driver with bursts, stalling result sink. Depends on vuart_pkg, vuart_if,
// vuart_tb_pkg and the unit itself.
`timescale 1ns / 100ps
module tb_top;
	import vuart_pkg::*;
	import vuart_tb_pkg::*;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PACED} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	vuart_req_if req();
	vuart_rsp_if rsp();

	vuart_tracker tracker;
	access_t stim_q[$];
	int burst_left = 0;
	int unsigned hold_requests = 0;

	virtual_uart_16550_registers_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	function void queue_access(input logic [1:0] f, input logic [2:0] o,
		input logic [7:0] d);
		stim_q.push_back('{func: f, offset: o, wdata: d});
	endfunction

	// Hold one beat on the request channel until it is taken.
	task automatic offer(input access_t a);
		req.valid <= 1'b1;
		req.func <= a.func;
		req.offset <= a.offset;
		req.wdata <= a.wdata;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		tracker.note_access(a);
	endtask

	task automatic send_all();
		while (stim_q.size() != 0) begin
			if (burst_left == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 16);
			end
			offer(stim_q.pop_front());
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (tracker.outstanding() != 0);
		@(posedge clk);
	endtask

	task automatic write_console(input logic on);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= on;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_console(on);
	endtask

	function void gen_random(input int n);
		int target;
		int k;
		int r;
		target = stim_q.size() + n;
		while (stim_q.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 24) begin
				// host bytes in, then read them back
				if ($urandom_range(0, 1)) begin
					queue_access(FUNC_WRITE, OFS_LCR, 8'($urandom) & 8'h7F);
				end
				k = $urandom_range(1, 10);
				repeat (k) queue_access(FUNC_RECV, OFS_DATA, 8'($urandom));
				queue_access(FUNC_READ, OFS_LSR, 8'($urandom));
				repeat ($urandom_range(0, k + 2))
					queue_access(FUNC_READ, OFS_DATA, 8'($urandom));
				if ($urandom_range(0, 1)) begin
					queue_access(FUNC_READ, OFS_IIR, 8'($urandom));
				end
			end else if (r < 48) begin
				// bytes out through THR, then drain them
				if ($urandom_range(0, 1)) begin
					queue_access(FUNC_WRITE, OFS_LCR, 8'($urandom) & 8'h7F);
				end
				k = $urandom_range(1, 10);
				repeat (k) queue_access(FUNC_WRITE, OFS_DATA, 8'($urandom));
				if ($urandom_range(0, 1)) begin
					queue_access(FUNC_READ, OFS_IIR, 8'($urandom));
				end
				repeat ($urandom_range(0, k + 2))
					queue_access(FUNC_DRAIN, 3'($urandom), 8'($urandom));
			end else if (r < 58) begin
				queue_access(FUNC_WRITE, OFS_IER, 8'($urandom));
				queue_access(FUNC_READ, OFS_IIR, 8'($urandom));
				queue_access(FUNC_READ, OFS_IER, 8'($urandom));
				queue_access(FUNC_READ, OFS_IIR, 8'($urandom));
			end else if (r < 66) begin
				// divisor latch access under DLAB
				queue_access(FUNC_WRITE, OFS_LCR, 8'h80 | 8'($urandom));
				queue_access(FUNC_READ, OFS_DATA, 8'($urandom));
				queue_access(FUNC_WRITE, OFS_DATA, 8'($urandom));
				queue_access(FUNC_WRITE, OFS_IER, 8'($urandom));
				queue_access(FUNC_READ, OFS_IER, 8'($urandom));
				queue_access(FUNC_READ, OFS_LCR, 8'($urandom));
				queue_access(FUNC_WRITE, OFS_LCR, 8'($urandom) & 8'h7F);
			end else if (r < 74) begin
				queue_access(FUNC_WRITE, OFS_FCR, 8'($urandom));
				queue_access(FUNC_READ, OFS_IIR, 8'($urandom));
			end else if (r < 80) begin
				queue_access(FUNC_WRITE, OFS_SCR, 8'($urandom));
				queue_access(FUNC_READ, OFS_SCR, 8'($urandom));
				queue_access(FUNC_WRITE, OFS_LSR, 8'($urandom));
				queue_access(FUNC_READ, OFS_LSR, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6))
					queue_access(2'($urandom), 3'($urandom), 8'($urandom));
			end
		end
	endfunction

	task automatic run_phase(input int n, input bit flood_rx, input bit flood_tx);
		gen_random(n / 2);
		send_all();
		// stall the sink for a long stretch while beats keep coming
		hold_requests <= hold_requests + 1;
		burst_left = 32;
		gen_random(24);
		send_all();
		wait_drained();
		if (flood_rx) begin
			queue_access(FUNC_WRITE, OFS_LCR, 8'($urandom) & 8'h7F);
			repeat ($urandom_range(257, 280))
				queue_access(FUNC_RECV, OFS_DATA, 8'($urandom));
		end
		if (flood_tx) begin
			queue_access(FUNC_WRITE, OFS_LCR, 8'($urandom) & 8'h7F);
			repeat ($urandom_range(257, 280))
				queue_access(FUNC_WRITE, OFS_DATA, 8'($urandom));
		end
		gen_random(n / 2);
		send_all();
	endtask

	initial begin : stimulus
		tracker = new();
		req.valid = 1'b0;
		req.func = FUNC_READ;
		req.offset = OFS_DATA;
		req.wdata = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_console(1'b0);
		queue_access(FUNC_READ, OFS_DATA, 8'h00);
		queue_access(FUNC_RECV, OFS_DATA, 8'hA5);
		queue_access(FUNC_DRAIN, OFS_DATA, 8'h00);
		queue_access(FUNC_WRITE, OFS_MCR, 8'hFF);
		queue_access(FUNC_READ, OFS_MSR, 8'h00);
		send_all();

		write_console(1'b1);
		queue_access(FUNC_WRITE, OFS_IER, 8'hFF);
		queue_access(FUNC_RECV, OFS_DATA, 8'h00);
		queue_access(FUNC_RECV, OFS_DATA, 8'hFF);
		queue_access(FUNC_READ, OFS_IIR, 8'h00);
		queue_access(FUNC_READ, OFS_LSR, 8'h00);
		queue_access(FUNC_READ, OFS_DATA, 8'h00);
		queue_access(FUNC_READ, OFS_DATA, 8'h00);
		queue_access(FUNC_READ, OFS_DATA, 8'h00);
		queue_access(FUNC_WRITE, OFS_DATA, 8'h00);
		queue_access(FUNC_READ, OFS_IIR, 8'h00);
		queue_access(FUNC_READ, OFS_IIR, 8'h00);
		queue_access(FUNC_DRAIN, OFS_DATA, 8'h00);
		queue_access(FUNC_DRAIN, OFS_DATA, 8'h00);
		queue_access(FUNC_WRITE, OFS_FCR, 8'hFF);
		queue_access(FUNC_READ, OFS_IIR, 8'h00);
		queue_access(FUNC_WRITE, OFS_FCR, 8'h00);
		queue_access(FUNC_WRITE, OFS_LCR, 8'hFF);
		queue_access(FUNC_READ, OFS_DATA, 8'h00);
		queue_access(FUNC_WRITE, OFS_IER, 8'hFF);
		queue_access(FUNC_READ, OFS_IER, 8'h00);
		queue_access(FUNC_WRITE, OFS_LCR, 8'h00);
		queue_access(FUNC_WRITE, OFS_SCR, 8'hFF);
		queue_access(FUNC_READ, OFS_SCR, 8'h00);
		send_all();

		run_phase(120, 1'b1, 1'b0);
		write_console(1'b0);
		run_phase(180, 1'b0, 1'b0);
		write_console(1'b1);
		run_phase(120, 1'b0, 1'b1);
		run_phase(200, 1'b0, 1'b0);

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Covered %0d accesses with console off and on; %0d compared, %0d irq.",
			tracker.noted, tracker.checked, tracker.irq_pulses);
		$display("Overwrites rx %0d tx %0d, empty RBR %0d, IIR THRE clears %0d, drained %0d.",
			tracker.rx_overwrites, tracker.tx_overwrites, tracker.empty_reads,
			tracker.thre_clears, tracker.tx_pops);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors, %0d results missing", tracker.errors, tracker.outstanding());
			$display("FAIL");
		end
		$finish;
	end

	// Result sink: stretches of varying stall patterns, plus long hold-offs on request.
	initial begin : sink_side
		int run;
		int pace;
		int unsigned holds_served;
		ready_mode_t mode;
		run = 0;
		pace = 1;
		holds_served = 0;
		mode = RDY_ALWAYS;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				rsp.ready <= 1'b0;
				repeat ($urandom_range(64, 96)) @(posedge clk);
			end else begin
				if (run == 0) begin
					mode = ready_mode_t'($urandom_range(0, 2));
					run = $urandom_range(8, 48);
					pace = $urandom_range(1, 6);
				end
				run--;
				case (mode)
				RDY_ALWAYS: rsp.ready <= 1'b1;
				RDY_COIN: rsp.ready <= 1'($urandom_range(0, 1));
				default: rsp.ready <= ((run % (pace + 1)) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : collect
		result_t got;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got.rdata = rsp.rdata;
			got.tx_byte = rsp.tx_byte;
			got.tx_valid = rsp.tx_valid;
			got.irq_pulse = rsp.irq_pulse;
			tracker.check_result(got);
		end
	end

	initial begin : watchdog
		#(10_000_000);
		$display("FAIL");
		$finish;
	end

endmodule
